// ===== design/mkw_pkg.sv =====
package mkw_pkg;

    localparam int DIST_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int T_W      = 16;
    localparam int DIV_STAGES = T_W;

    localparam logic [WEIGHT_W-1:0] W_ONE = 17'h10000;

    localparam logic [2:0] KS_UNIFORM = 3'd0;
    localparam logic [2:0] KS_WYVILL  = 3'd1;
    localparam logic [2:0] KS_HART    = 3'd2;
    localparam logic [2:0] KS_BLINN   = 3'd3;
    localparam logic [2:0] KS_LINKS   = 3'd4;
    localparam logic [2:0] KS_HERON   = 3'd5;
    localparam logic [2:0] KS_ELENDT  = 3'd6;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_BLEND  = 1'b1;

    localparam logic [2:0] CFG_KERNEL_SELECT      = 3'd0;
    localparam logic [2:0] CFG_KERNEL_RADIUS      = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD_ENABLE   = 3'd2;
    localparam logic [2:0] CFG_DISTANCE_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_BLEND_WIDTH        = 3'd4;
    localparam logic [2:0] CFG_UNIFORM_BIAS       = 3'd5;

    typedef struct packed {
        logic                fixed;
        logic [WEIGHT_W-1:0] fixed_val;
        logic [2:0]          sel;
    } mkw_ctl_t;

    function automatic logic [23:0] mul_q(input logic [19:0] a, input logic [19:0] b);
        logic [39:0] p;
        p = a * b;
        return p[39:16];
    endfunction

endpackage

// ===== design/mkw_front.sv =====
module mkw_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [mkw_pkg::DIST_W-1:0]    in_dist,
    input  logic [2:0]                    kernel_select,
    input  logic [mkw_pkg::DIST_W-1:0]    radius,
    input  logic                          threshold_enable,
    input  logic [mkw_pkg::DIST_W-1:0]    thr_level,
    input  logic [mkw_pkg::DIST_W-1:0]    feather_span,
    input  logic [mkw_pkg::WEIGHT_W-1:0]  flat_bias,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mkw_pkg::mkw_ctl_t             out_ctl,
    output logic [mkw_pkg::DIST_W-1:0]    out_e,
    output logic [mkw_pkg::DIST_W-1:0]    out_s
);

    logic                       valid_reg;
    mkw_pkg::mkw_ctl_t          ctl_reg, ctl_next;
    logic [mkw_pkg::DIST_W-1:0] e_reg, e_next, s_reg, s_next;
    logic [mkw_pkg::DIST_W:0]   feather_end;

    assign in_ready    = !valid_reg || out_ready;
    assign feather_end = {1'b0, thr_level} + {1'b0, feather_span};

    always_comb begin
        ctl_next.fixed     = 1'b1;
        ctl_next.fixed_val = '0;
        ctl_next.sel       = kernel_select;
        e_next             = in_dist;
        s_next             = radius;
        if (in_op == mkw_pkg::OP_SAMPLE) begin
            priority if (radius == '0) begin
                ctl_next.fixed_val = (in_dist == '0) ? mkw_pkg::W_ONE : '0;
            end else if (kernel_select == mkw_pkg::KS_UNIFORM) begin
                ctl_next.fixed_val = (in_dist <= radius) ? mkw_pkg::W_ONE : '0;
            end else if (in_dist >= radius) begin
                ctl_next.fixed_val = '0;
            end else begin
                ctl_next.fixed = 1'b0;
            end
        end else begin
            e_next = in_dist - thr_level;
            s_next = feather_span;
            priority if (!threshold_enable || in_dist <= thr_level) begin
                ctl_next.fixed_val = mkw_pkg::W_ONE;
            end else if (feather_span == '0 || {1'b0, in_dist} > feather_end) begin
                ctl_next.fixed_val = '0;
            end else if (kernel_select == mkw_pkg::KS_UNIFORM) begin
                ctl_next.fixed_val = (flat_bias > mkw_pkg::W_ONE) ? mkw_pkg::W_ONE
                                                                    : flat_bias;
            end else if ({1'b0, in_dist} == feather_end) begin
                ctl_next.fixed_val = '0;
            end else begin
                ctl_next.fixed = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            ctl_reg <= ctl_next;
            e_reg   <= e_next;
            s_reg   <= s_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_e     = e_reg;
    assign out_s     = s_reg;

endmodule

// ===== design/mkw_div.sv =====
module mkw_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  mkw_pkg::mkw_ctl_t          in_ctl,
    input  logic [mkw_pkg::DIST_W-1:0] in_e,
    input  logic [mkw_pkg::DIST_W-1:0] in_s,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mkw_pkg::mkw_ctl_t          out_ctl,
    output logic [mkw_pkg::T_W-1:0]    out_t
);

    localparam int N = mkw_pkg::DIV_STAGES;

    logic                       valid_reg [N];
    mkw_pkg::mkw_ctl_t          ctl_reg   [N];
    logic [mkw_pkg::DIST_W-1:0] rem_reg   [N];
    logic [mkw_pkg::DIST_W-1:0] s_reg     [N];
    logic [mkw_pkg::T_W-1:0]    q_reg     [N];
    logic [mkw_pkg::DIST_W-1:0] rem_next  [N];
    logic [mkw_pkg::T_W-1:0]    q_next    [N];
    logic                       adv       [N+1];

    always_comb begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_comb begin
        logic [mkw_pkg::DIST_W:0]   r2;
        logic [mkw_pkg::DIST_W-1:0] rp;
        logic [mkw_pkg::DIST_W-1:0] sp;
        logic [mkw_pkg::T_W-1:0]    qp;
        for (int k = 0; k < N; k++) begin
            rp = (k == 0) ? in_e : rem_reg[(k == 0) ? 0 : k - 1];
            sp = (k == 0) ? in_s : s_reg[(k == 0) ? 0 : k - 1];
            qp = (k == 0) ? '0 : q_reg[(k == 0) ? 0 : k - 1];
            r2 = {rp, 1'b0};
            if (r2 >= {1'b0, sp}) begin
                r2          = r2 - {1'b0, sp};
                q_next[k]   = {qp[mkw_pkg::T_W-2:0], 1'b1};
            end else begin
                q_next[k]   = {qp[mkw_pkg::T_W-2:0], 1'b0};
            end
            rem_next[k] = r2[mkw_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < N; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (adv[k]) begin
                ctl_reg[k] <= (k == 0) ? in_ctl : ctl_reg[(k == 0) ? 0 : k - 1];
                s_reg[k]   <= (k == 0) ? in_s : s_reg[(k == 0) ? 0 : k - 1];
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
    assign out_t     = q_reg[N-1];

endmodule

// ===== design/mkw_poly.sv =====
module mkw_poly (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mkw_pkg::mkw_ctl_t            in_ctl,
    input  logic [mkw_pkg::T_W-1:0]      in_t,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mkw_pkg::WEIGHT_W-1:0] out_weight
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    mkw_pkg::mkw_ctl_t c1_reg, c2_reg, c3_reg;

    logic [15:0] p1_t_reg, p1_t2_reg;
    logic [16:0] p1_u1_reg;
    logic [15:0] p2_t_reg, p2_t3_reg, p2_t4_reg;
    logic [16:0] p2_uq_reg, p2_uut_reg, p2_uuq_reg;
    logic [15:0] p3_t_reg, p3_t3_reg, p3_t4_reg;
    logic [17:0] p3_m_reg;
    logic [16:0] p4_w_reg;

    logic [16:0] uq;
    logic [17:0] m_next;
    logic [16:0] w_next;
    logic [23:0] prod3, prod4;
    logic signed [23:0] hart;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign uq = mkw_pkg::W_ONE - {1'b0, p1_t2_reg};

    always_comb begin
        unique case (c2_reg.sel)
            mkw_pkg::KS_WYVILL: prod3 = mkw_pkg::mul_q(20'(p2_uuq_reg), 20'(p2_uq_reg));
            mkw_pkg::KS_HART:   prod3 = mkw_pkg::mul_q(20'(p2_t4_reg), 20'(p2_t_reg));
            mkw_pkg::KS_BLINN:  prod3 = 24'(p2_uuq_reg);
            mkw_pkg::KS_LINKS:  prod3 = mkw_pkg::mul_q(20'(p2_uut_reg),
                                    20'(mkw_pkg::W_ONE) + {3'b0, p2_t_reg, 1'b0});
            mkw_pkg::KS_HERON:  prod3 = mkw_pkg::mul_q(20'(p2_uuq_reg),
                                    20'(20'd3 * 20'(mkw_pkg::W_ONE)) - {2'b0, p2_uq_reg, 1'b0});
            default:            prod3 = mkw_pkg::mul_q(20'(p2_uut_reg), 20'(p2_uut_reg));
        endcase
        m_next = prod3[17:0];
    end

    always_comb begin
        hart  = $signed(24'(mkw_pkg::W_ONE))
              - $signed(24'd6 * {8'b0, p3_m_reg[15:0]})
              + $signed(24'd15 * {8'b0, p3_t4_reg})
              - $signed(24'd10 * {8'b0, p3_t3_reg});
        prod4 = mkw_pkg::mul_q(20'(p3_m_reg), {2'b0, p3_t_reg, 2'b0} + 20'(mkw_pkg::W_ONE));
        w_next = p3_m_reg[16:0];
        if (c3_reg.fixed) begin
            w_next = c3_reg.fixed_val;
        end else begin
            unique case (c3_reg.sel)
                mkw_pkg::KS_HART: begin
                    priority if (hart < 0) begin
                        w_next = '0;
                    end else if (hart > $signed(24'(mkw_pkg::W_ONE))) begin
                        w_next = mkw_pkg::W_ONE;
                    end else begin
                        w_next = hart[16:0];
                    end
                end
                mkw_pkg::KS_WYVILL, mkw_pkg::KS_BLINN, mkw_pkg::KS_LINKS,
                mkw_pkg::KS_HERON, mkw_pkg::KS_UNIFORM: begin
                    w_next = (p3_m_reg > 18'(mkw_pkg::W_ONE)) ? mkw_pkg::W_ONE
                                                              : p3_m_reg[16:0];
                end
                default: begin
                    w_next = (prod4 > 24'(mkw_pkg::W_ONE)) ? mkw_pkg::W_ONE : prod4[16:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [23:0] sq;
        sq = mkw_pkg::mul_q(20'(in_t), 20'(in_t));
        if (adv1) begin
            c1_reg    <= in_ctl;
            p1_t_reg  <= in_t;
            p1_t2_reg <= sq[15:0];
            p1_u1_reg <= mkw_pkg::W_ONE - {1'b0, in_t};
        end
    end

    always_ff @(posedge aclk) begin
        logic [23:0] a, b, c, d;
        a = mkw_pkg::mul_q(20'(p1_t2_reg), 20'(p1_t_reg));
        b = mkw_pkg::mul_q(20'(p1_t2_reg), 20'(p1_t2_reg));
        c = mkw_pkg::mul_q(20'(p1_u1_reg), 20'(p1_u1_reg));
        d = mkw_pkg::mul_q(20'(uq), 20'(uq));
        if (adv2) begin
            c2_reg     <= c1_reg;
            p2_t_reg   <= p1_t_reg;
            p2_t3_reg  <= a[15:0];
            p2_t4_reg  <= b[15:0];
            p2_uut_reg <= c[16:0];
            p2_uuq_reg <= d[16:0];
            p2_uq_reg  <= uq;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            c3_reg    <= c2_reg;
            p3_t_reg  <= p2_t_reg;
            p3_t3_reg <= p2_t3_reg;
            p3_t4_reg <= p2_t4_reg;
            p3_m_reg  <= m_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            p4_w_reg <= w_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_weight = p4_w_reg;

endmodule

// ===== design/metaball_kernel_weight_top.sv =====
// Metaball falloff kernel weight. Each request carries an opcode (s_tuser: 0 sample
// weight, 1 blend feather factor) and a Q16.16 distance (s_tdata[31:0]); each gives one
// Q1.16 weight on m_tdata[16:0]. One request is taken every cycle unless m_tready
// holds the output back; each passes through the decode stage, the 16-stage restoring
// divider that normalises the distance, four polynomial stages and the output register.
// Write the configuration registers only while no request is in flight.
module metaball_kernel_weight_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] distance
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] weight
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    logic [2:0]  kernel_select_reg;
    logic [31:0] radius_reg;
    logic        threshold_enable_reg;
    logic [31:0] thr_level_reg;
    logic [31:0] feather_span_reg;
    logic [16:0] flat_bias_reg;

    logic              f_valid, f_ready, d_valid, d_ready, p_valid, p_ready;
    mkw_pkg::mkw_ctl_t f_ctl, d_ctl;
    logic [31:0]       f_e, f_s;
    logic [15:0]       d_t;
    logic [16:0]       p_weight;
    logic              m_valid_reg;
    logic [16:0]       m_weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_select_reg    <= mkw_pkg::KS_ELENDT;
            radius_reg           <= 32'h0001_0000;
            threshold_enable_reg <= 1'b0;
            thr_level_reg        <= '0;
            feather_span_reg     <= '0;
            flat_bias_reg        <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mkw_pkg::CFG_KERNEL_SELECT:      kernel_select_reg    <= cfg_wdata[2:0];
                mkw_pkg::CFG_KERNEL_RADIUS:      radius_reg           <= cfg_wdata;
                mkw_pkg::CFG_THRESHOLD_ENABLE:   threshold_enable_reg <= cfg_wdata[0];
                mkw_pkg::CFG_DISTANCE_THRESHOLD: thr_level_reg        <= cfg_wdata;
                mkw_pkg::CFG_BLEND_WIDTH:        feather_span_reg     <= cfg_wdata;
                mkw_pkg::CFG_UNIFORM_BIAS:       flat_bias_reg        <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    mkw_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_op            (s_tuser),
        .in_dist          (s_tdata),
        .kernel_select    (kernel_select_reg),
        .radius           (radius_reg),
        .threshold_enable (threshold_enable_reg),
        .thr_level        (thr_level_reg),
        .feather_span     (feather_span_reg),
        .flat_bias        (flat_bias_reg),
        .out_valid        (f_valid),
        .out_ready        (f_ready),
        .out_ctl          (f_ctl),
        .out_e            (f_e),
        .out_s            (f_s)
    );

    mkw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_ctl    (f_ctl),
        .in_e      (f_e),
        .in_s      (f_s),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_ctl   (d_ctl),
        .out_t     (d_t)
    );

    mkw_poly u_poly (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .in_ctl     (d_ctl),
        .in_t       (d_t),
        .out_valid  (p_valid),
        .out_ready  (p_ready),
        .out_weight (p_weight)
    );

    assign p_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p_ready) begin
            m_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready) begin
            m_weight_reg <= p_weight;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_weight_reg};

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_weight_reg <= mkw_pkg::W_ONE))
        else $error("weight above one");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_cfg_select: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && cfg_addr == mkw_pkg::CFG_KERNEL_SELECT)
        |=> (kernel_select_reg == $past(cfg_wdata[2:0])))
        else $error("kernel select not written");

endmodule
